>>> rtl/core/sal_pkg.sv
// ----------------------------------------------------------------------------
// Security access lockout package
// Shared constants, codes and structs for the security access lockout block.
// ----------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

    // Number of level entries and width of the tick counter and deadlines.
    localparam int LEVEL_COUNT = 256;
    localparam int TIME_BITS   = 32;

    // Derived widths.
    localparam int LEVEL_BITS  = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int LEVEL_W     = 8;
    localparam int COUNT_W     = 8;
    localparam int TICKS_W     = 32;
    localparam int SUM_W       = ((TIME_BITS > TICKS_W) ? TIME_BITS : TICKS_W) + 1;

    // Action codes of a request item.
    localparam logic [2:0] ACT_SEED        = 3'd0;
    localparam logic [2:0] ACT_KEY         = 3'd1;
    localparam logic [2:0] ACT_LOCK        = 3'd2;
    localparam logic [2:0] ACT_CLEAR_ALL   = 3'd3;
    localparam logic [2:0] ACT_TICK        = 3'd4;
    localparam logic [2:0] ACT_QUERY_UNL   = 3'd5;
    localparam logic [2:0] ACT_QUERY_ATT   = 3'd6;

    // Status codes of a response item.
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NOENGINE     = 2'd1;
    localparam logic [1:0] ST_DENIED       = 2'd2;

    // Configuration register indexes.
    localparam logic REG_FAIL_LIMIT    = 1'b0;
    localparam logic REG_LOCKOUT_TICKS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] FAIL_LIMIT_RST    = 8'd3;
    localparam logic [TICKS_W-1:0] LOCKOUT_TICKS_RST = 32'd10000;

    // One level entry as held in the entry memory.
    typedef struct packed {
        logic                 seed_pending;
        logic                 unlocked;
        logic [COUNT_W-1:0]   fail_count;
        logic [TIME_BITS-1:0] deadline;
    } entry_t;

    // Write port of the entry store.
    typedef struct packed {
        logic                  en;
        logic                  set_valid;
        logic [LEVEL_BITS-1:0] addr;
        entry_t                data;
    } store_wr_t;

    // Registered read result of the entry store.
    typedef struct packed {
        logic   valid;
        entry_t data;
    } store_rd_t;

    // Current configuration.
    typedef struct packed {
        logic [COUNT_W-1:0] fail_limit;
        logic [TICKS_W-1:0] lockout_ticks;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/sal_ifs.sv
// ----------------------------------------------------------------------------
// Security access lockout channels
// Valid/ready interfaces for requests, responses and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one item per access request.
interface sal_req_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  action;
    logic [sal_pkg::LEVEL_W-1:0] level;
    logic                        engine_ready;
    logic                        seed_ok;
    logic                        key_valid;

    modport source (output valid, action, level, engine_ready, seed_ok, key_valid,
                    input ready);
    modport sink   (input valid, action, level, engine_ready, seed_ok, key_valid,
                    output ready);
endinterface

// Response channel: one item per request.
interface sal_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic                        unlocked;
    logic [sal_pkg::COUNT_W-1:0] attempts;
    logic                        lockout_started;

    modport source (output valid, status, unlocked, attempts, lockout_started,
                    input ready);
    modport sink   (input valid, status, unlocked, attempts, lockout_started,
                    output ready);
endinterface

// Configuration write channel.
interface sal_cfg_if;
    logic                        valid;
    logic                        ready;
    logic                        index;
    logic [sal_pkg::TICKS_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sal_cfg_regs.sv
// ----------------------------------------------------------------------------
// Security access lockout configuration registers
// Holds the attempt limit and the lockout duration written over the cfg port.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sal_cfg_if.sink      cfg,
    output sal_pkg::cfg_t cfg_val
);

    logic [sal_pkg::COUNT_W-1:0] max_att_reg;
    logic [sal_pkg::TICKS_W-1:0] lock_ticks_reg;
    logic                        wr_en;

    // Writes are always taken.
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_att_reg    <= sal_pkg::FAIL_LIMIT_RST;
            lock_ticks_reg <= sal_pkg::LOCKOUT_TICKS_RST;
        end
        else if (wr_en)
        begin
            case (cfg.index)
                sal_pkg::REG_FAIL_LIMIT:    max_att_reg    <= cfg.data[sal_pkg::COUNT_W-1:0];
                sal_pkg::REG_LOCKOUT_TICKS: lock_ticks_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg_val.fail_limit    = max_att_reg;
    assign cfg_val.lockout_ticks = lock_ticks_reg;

endmodule

`default_nettype wire

>>> rtl/core/sal_entry_store.sv
// ----------------------------------------------------------------------------
// Security access lockout entry store
// Per-level entry memory with one registered read port and one write port,
// plus a flip-flop valid bit per level that clear-all resets at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_entry_store (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rd_en,
    input  wire logic [sal_pkg::LEVEL_BITS-1:0] rd_addr,
    input  sal_pkg::store_wr_t                  wr,
    input  wire logic                           clear_all,
    output sal_pkg::store_rd_t                  rd
);

    sal_pkg::entry_t                   mem [sal_pkg::LEVEL_COUNT];
    logic [sal_pkg::LEVEL_COUNT-1:0]   valid_reg;
    sal_pkg::entry_t                   rd_data_reg;
    logic                              rd_valid_reg;

    // Entry memory: synchronous write, registered read.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits, cleared by reset and by clear-all.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr.en && wr.set_valid)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.data  = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/security_access_lockout_top.sv
// ----------------------------------------------------------------------------
// Security access lockout top level
// Seed/key security access gate with per-level attempt counting and lockout.
// ----------------------------------------------------------------------------
// Each item has an accept cycle and an evaluate state. In the accept cycle the
// level entry is read from the entry memory; in the evaluate state it is
// evaluated, written back and the response item is loaded into the output
// register. The single memory read port and the read-modify-write of one entry
// set this split; a response that is not taken holds the evaluate state until
// the output register frees. One item is in flight at a time, so a write-back
// always lands before the next read. Entry valid bits are flip-flops that
// reset and clear-all empty at once, so there is no clearing pass after reset.
// Configuration writes are taken at any time and should be made while idle.
`default_nettype none

module security_access_lockout_top (
    input  wire logic clk,
    input  wire logic rst_n,
    sal_cfg_if.sink   cfg,
    sal_req_if.sink   req,
    sal_rsp_if.source rsp
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    localparam int LW = sal_pkg::LEVEL_W;
    localparam int TB = sal_pkg::TIME_BITS;
    localparam int SW = sal_pkg::SUM_W;

    localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

    sal_pkg::cfg_t      cfg_val;
    sal_pkg::store_wr_t st_wr;
    sal_pkg::store_rd_t st_rd;

    state_t                      state_reg, state_next;
    logic [2:0]                  action_reg, action_next;
    logic                        eng_reg, eng_next;
    logic                        seed_ok_reg, seed_ok_next;
    logic                        key_ok_reg, key_ok_next;
    logic                        inr_reg, inr_next;
    logic [sal_pkg::LEVEL_BITS-1:0] addr_reg, addr_next;
    logic [TB-1:0]               tick_reg, tick_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [1:0]                  status_reg, status_next;
    logic                        unl_reg, unl_next;
    logic [sal_pkg::COUNT_W-1:0] att_reg, att_next;
    logic                        started_reg, started_next;

    logic                        accept;
    logic                        out_free;
    logic                        finish;
    logic [LW-1:0]               sel_level;
    logic                        ent_v;
    logic                        locked;
    logic [sal_pkg::COUNT_W-1:0] cnt_inc;
    logic [SW-1:0]               dl_sum;
    logic [TB-1:0]               dl_sat;
    logic                        clear_all;
    sal_pkg::entry_t             ent;

    // Configuration registers.
    sal_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    // Level entry memory.
    sal_entry_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (addr_next),
        .wr        (st_wr),
        .clear_all (clear_all),
        .rd        (st_rd)
    );

    // Handshakes.
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign finish    = (state_reg == S_EXEC) && out_free;

    // Entry selection: a key on a nonzero level checks the level below, an unlock
    // query on an even nonzero level checks the level below.
    always_comb
    begin
        sel_level = req.level;
        case (req.action)
            sal_pkg::ACT_KEY:
            begin
                if (req.level != '0)
                begin
                    sel_level = req.level - LW'(1);
                end
            end
            sal_pkg::ACT_QUERY_UNL:
            begin
                if (!req.level[0] && (req.level != '0))
                begin
                    sel_level = req.level - LW'(1);
                end
            end
            default: ;
        endcase
    end

    // Entry evaluation from the registered read.
    assign ent     = st_rd.data;
    assign ent_v   = st_rd.valid && inr_reg;
    assign locked  = ent_v && (ent.fail_count >= cfg_val.fail_limit) && (tick_reg < ent.deadline);
    assign cnt_inc = (ent.fail_count == {sal_pkg::COUNT_W{1'b1}})
                     ? ent.fail_count : ent.fail_count + sal_pkg::COUNT_W'(1);

    // Saturating lockout deadline.
    assign dl_sum = SW'(tick_reg) + SW'(cfg_val.lockout_ticks);
    assign dl_sat = (dl_sum > SW'(TIME_MAX)) ? TIME_MAX : dl_sum[TB-1:0];

    // Next-state and response logic.
    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        eng_next       = eng_reg;
        seed_ok_next   = seed_ok_reg;
        key_ok_next    = key_ok_reg;
        inr_next       = inr_reg;
        addr_next      = sel_level[sal_pkg::LEVEL_BITS-1:0];
        tick_next      = tick_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        unl_next       = unl_reg;
        att_next       = att_reg;
        started_next   = started_reg;
        clear_all      = 1'b0;
        st_wr.en        = 1'b0;
        st_wr.set_valid = 1'b0;
        st_wr.addr      = addr_reg;
        st_wr.data      = ent;

        // Capture a new request item.
        if (accept)
        begin
            state_next   = S_EXEC;
            action_next  = req.action;
            eng_next     = req.engine_ready;
            seed_ok_next = req.seed_ok;
            key_ok_next  = req.key_valid;
            inr_next     = ({1'b0, sel_level} < (LW + 1)'(sal_pkg::LEVEL_COUNT));
        end

        // Evaluate, write back and respond.
        if (finish)
        begin
            state_next     = S_IDLE;
            rsp_valid_next = 1'b1;
            status_next    = sal_pkg::ST_OK;
            unl_next       = 1'b0;
            att_next       = '0;
            started_next   = 1'b0;
            case (action_reg)
                sal_pkg::ACT_SEED:
                begin
                    if (!eng_reg)
                    begin
                        status_next = sal_pkg::ST_NOENGINE;
                    end
                    else if (locked)
                    begin
                        status_next = sal_pkg::ST_DENIED;
                    end
                    else if (!seed_ok_reg)
                    begin
                        status_next = sal_pkg::ST_NOENGINE;
                    end
                    else if (!inr_reg)
                    begin
                        status_next = sal_pkg::ST_DENIED;
                    end
                    else
                    begin
                        st_wr.en        = 1'b1;
                        st_wr.set_valid = 1'b1;
                        if (!ent_v)
                        begin
                            st_wr.data.fail_count = '0;
                            st_wr.data.deadline   = '0;
                        end
                        st_wr.data.seed_pending = 1'b1;
                        st_wr.data.unlocked     = 1'b0;
                    end
                end
                sal_pkg::ACT_KEY:
                begin
                    if (!eng_reg)
                    begin
                        status_next = sal_pkg::ST_NOENGINE;
                    end
                    else if (!ent_v || !ent.seed_pending || locked)
                    begin
                        status_next = sal_pkg::ST_DENIED;
                    end
                    else if (!key_ok_reg)
                    begin
                        status_next             = sal_pkg::ST_DENIED;
                        st_wr.en                = 1'b1;
                        st_wr.data.fail_count   = cnt_inc;
                        st_wr.data.seed_pending = 1'b0;
                        if (cnt_inc >= cfg_val.fail_limit)
                        begin
                            st_wr.data.deadline = dl_sat;
                            started_next        = 1'b1;
                        end
                    end
                    else
                    begin
                        st_wr.en                = 1'b1;
                        st_wr.data.unlocked     = 1'b1;
                        st_wr.data.seed_pending = 1'b0;
                        st_wr.data.fail_count   = '0;
                    end
                end
                sal_pkg::ACT_LOCK:
                begin
                    if (ent_v)
                    begin
                        st_wr.en                = 1'b1;
                        st_wr.data.unlocked     = 1'b0;
                        st_wr.data.seed_pending = 1'b0;
                    end
                end
                sal_pkg::ACT_CLEAR_ALL:
                begin
                    clear_all = 1'b1;
                end
                sal_pkg::ACT_TICK:
                begin
                    if (tick_reg != TIME_MAX)
                    begin
                        tick_next = tick_reg + TB'(1);
                    end
                end
                sal_pkg::ACT_QUERY_UNL:
                begin
                    unl_next = ent_v && ent.unlocked;
                end
                sal_pkg::ACT_QUERY_ATT:
                begin
                    if (ent_v)
                    begin
                        att_next = ent.fail_count;
                    end
                end
                default: ;
            endcase
        end
    end

    // State, item capture, tick counter and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            action_reg    <= '0;
            eng_reg       <= 1'b0;
            seed_ok_reg   <= 1'b0;
            key_ok_reg    <= 1'b0;
            inr_reg       <= 1'b0;
            addr_reg      <= '0;
            tick_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= sal_pkg::ST_OK;
            unl_reg       <= 1'b0;
            att_reg       <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            action_reg    <= action_next;
            eng_reg       <= eng_next;
            seed_ok_reg   <= seed_ok_next;
            key_ok_reg    <= key_ok_next;
            inr_reg       <= inr_next;
            if (accept)
            begin
                addr_reg <= addr_next;
            end
            tick_reg      <= tick_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            unl_reg       <= unl_next;
            att_reg       <= att_next;
            started_reg   <= started_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.unlocked        = unl_reg;
    assign rsp.attempts        = att_reg;
    assign rsp.lockout_started = started_reg;

`ifndef SYNTHESIS
    // An accepted item always moves to the evaluate cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter evaluation");

    // The evaluate cycle waits while the output register is held.
    a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && !out_free) |=> (state_reg == S_EXEC))
        else $error("evaluation finished over a held response");

    // A new lockout is only reported with a denial.
    a_started_denied: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && started_reg) |-> (status_reg == sal_pkg::ST_DENIED))
        else $error("lockout started without denial");

    // The tick counter never moves backward.
    a_tick_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (tick_reg >= $past(tick_reg)))
        else $error("tick counter decreased");

    // The entry memory is never read and written in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && st_wr.en))
        else $error("entry read overlaps write-back");
`endif

endmodule

`default_nettype wire
